// ===== rtl/rtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 16;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 67;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TRANS = 2'd1;
    localparam logic [1:0] CMD_ROT   = 2'd2;

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);

    // 2*pi in Q32 is 6 * 2^32 plus this remainder
    localparam logic [30:0] TWOPI_LO = 31'd1216271633;

    // reciprocals floor(2^(32+l) / d), l = floor(log2 d), d = 2 taken with l = 0
    localparam logic [31:0] RCP_6   = 32'((64'd1 << 34) / 64'd6);
    localparam logic [31:0] RCP_20  = 32'((64'd1 << 36) / 64'd20);
    localparam logic [31:0] RCP_42  = 32'((64'd1 << 37) / 64'd42);
    localparam logic [31:0] RCP_72  = 32'((64'd1 << 38) / 64'd72);
    localparam logic [31:0] RCP_110 = 32'((64'd1 << 38) / 64'd110);
    localparam logic [31:0] RCP_156 = 32'((64'd1 << 39) / 64'd156);
    localparam logic [31:0] RCP_210 = 32'((64'd1 << 39) / 64'd210);
    localparam logic [31:0] RCP_2   = 32'((64'd1 << 32) / 64'd2);
    localparam logic [31:0] RCP_12  = 32'((64'd1 << 35) / 64'd12);
    localparam logic [31:0] RCP_30  = 32'((64'd1 << 36) / 64'd30);
    localparam logic [31:0] RCP_56  = 32'((64'd1 << 37) / 64'd56);
    localparam logic [31:0] RCP_90  = 32'((64'd1 << 38) / 64'd90);
    localparam logic [31:0] RCP_132 = 32'((64'd1 << 39) / 64'd132);
    localparam logic [31:0] RCP_182 = 32'((64'd1 << 39) / 64'd182);

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         row_sel;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
    } req_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic signed [31:0] mat_c0;
        logic signed [31:0] mat_c1;
        logic signed [31:0] mat_c2;
        logic signed [31:0] mat_c3;
        logic signed [31:0] inv_c0;
        logic signed [31:0] inv_c1;
        logic signed [31:0] inv_c2;
        logic signed [31:0] inv_c3;
        logic               last_row;
    } rsp_t;

    function automatic logic signed [ACC_W-1:0] sext32(input logic signed [31:0] x);
        return {{(ACC_W-32){x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1)
            return v[31:0];
        else if (v[ACC_W-1])
            return 32'sh8000_0000;
        else
            return 32'sh7fff_ffff;
    endfunction

    // Q32 series result to Qn.FRAC_BITS, round half up
    function automatic logic signed [31:0] to_frac(input logic [32:0] v);
        logic [33:0] t;
        t = {1'b0, v} + (34'd1 << (31 - FRAC_BITS));
        return $signed(32'(t >> (32 - FRAC_BITS)));
    endfunction

    function automatic logic [7:0] ser_div(input logic odd, input logic [2:0] n);
        logic [7:0] d;
        case ({odd, n})
            4'b1001: d = 8'd6;
            4'b1010: d = 8'd20;
            4'b1011: d = 8'd42;
            4'b1100: d = 8'd72;
            4'b1101: d = 8'd110;
            4'b1110: d = 8'd156;
            4'b1111: d = 8'd210;
            4'b0001: d = 8'd2;
            4'b0010: d = 8'd12;
            4'b0011: d = 8'd30;
            4'b0100: d = 8'd56;
            4'b0101: d = 8'd90;
            4'b0110: d = 8'd132;
            4'b0111: d = 8'd182;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] ser_rcp(input logic odd, input logic [2:0] n);
        logic [31:0] r;
        case ({odd, n})
            4'b1001: r = RCP_6;
            4'b1010: r = RCP_20;
            4'b1011: r = RCP_42;
            4'b1100: r = RCP_72;
            4'b1101: r = RCP_110;
            4'b1110: r = RCP_156;
            4'b1111: r = RCP_210;
            4'b0001: r = RCP_2;
            4'b0010: r = RCP_12;
            4'b0011: r = RCP_30;
            4'b0100: r = RCP_56;
            4'b0101: r = RCP_90;
            4'b0110: r = RCP_132;
            4'b0111: r = RCP_182;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ser_sh(input logic odd, input logic [2:0] n);
        logic [2:0] s;
        case ({odd, n})
            4'b1001: s = 3'd2;
            4'b1010: s = 3'd4;
            4'b1011: s = 3'd5;
            4'b1100: s = 3'd6;
            4'b1101: s = 3'd6;
            4'b1110: s = 3'd7;
            4'b1111: s = 3'd7;
            4'b0001: s = 3'd0;
            4'b0010: s = 3'd3;
            4'b0011: s = 3'd4;
            4'b0100: s = 3'd5;
            4'b0101: s = 3'd6;
            4'b0110: s = 3'd7;
            4'b0111: s = 3'd7;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rigid_transform_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load-row, translate and no-op commands go straight to the inverse translation pass; rotate
// first runs three sine/cosine evaluations, three 3x3 product passes and a copy step, then
// the inverse pass, all on one 34x34 multiplier.
// One command at a time: req_ready stays low until all three result rows have been taken.
// Reset: asynchronous, active low; matrix and inverse return to identity.
module rigid_transform_update (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rtu_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rtu_pkg::rsp_t rsp
);
    import rtu_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ANG  = 4'd1;
    localparam logic [3:0] S_X    = 4'd2;
    localparam logic [3:0] S_X2   = 4'd3;
    localparam logic [3:0] S_X2W  = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_T2   = 4'd6;
    localparam logic [3:0] S_T3   = 4'd7;
    localparam logic [3:0] S_T4   = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_MMUL = 4'd10;
    localparam logic [3:0] S_MACC = 4'd11;
    localparam logic [3:0] S_COPY = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] PASS_INV = 2'd3;

    function automatic logic signed [31:0] rot_elem(input logic [1:0] axis,
                                                    input logic [1:0] r,
                                                    input logic [1:0] c,
                                                    input logic signed [31:0] sv,
                                                    input logic signed [31:0] cv);
        logic signed [31:0] e;
        e = '0;
        case (axis)
            AX_X:
            begin
                case ({r, c})
                    4'h0:    e = ONE_FX;
                    4'h5:    e = cv;
                    4'h6:    e = -sv;
                    4'h9:    e = sv;
                    4'hA:    e = cv;
                    default: e = '0;
                endcase
            end
            AX_Y:
            begin
                case ({r, c})
                    4'h0:    e = cv;
                    4'h2:    e = sv;
                    4'h5:    e = ONE_FX;
                    4'h8:    e = -sv;
                    4'hA:    e = cv;
                    default: e = '0;
                endcase
            end
            AX_Z:
            begin
                case ({r, c})
                    4'h0:    e = cv;
                    4'h1:    e = -sv;
                    4'h4:    e = sv;
                    4'h5:    e = cv;
                    4'hA:    e = ONE_FX;
                    default: e = '0;
                endcase
            end
            default: e = '0;
        endcase
        return e;
    endfunction

    logic [3:0]         state_reg, state_next;
    logic signed [31:0] mdl_reg [3][4];
    logic signed [31:0] mdl_next [3][4];
    logic signed [31:0] invt_reg [3];
    logic signed [31:0] invt_next [3];
    logic signed [31:0] p_reg [3][3];
    logic signed [31:0] p_next [3][3];
    logic signed [31:0] q_reg [3][3];
    logic signed [31:0] q_next [3][3];
    logic signed [31:0] sin_reg [3];
    logic signed [31:0] sin_next [3];
    logic signed [31:0] cos_reg [3];
    logic signed [31:0] cos_next [3];
    logic [15:0]        ang_reg [3];
    logic [15:0]        ang_next [3];
    logic [1:0]         aidx_reg, aidx_next;
    logic [1:0]         quad_reg, quad_next;
    logic               swap_reg, swap_next;
    logic [29:0]        rf_reg, rf_next;
    logic [31:0]        x_reg, x_next;
    logic [31:0]        x2_reg, x2_next;
    logic [32:0]        term_reg, term_next;
    logic signed [34:0] sum_reg, sum_next;
    logic               odd_reg, odd_next;
    logic [2:0]         n_reg, n_next;
    logic [31:0]        v_reg, v_next;
    logic [31:0]        qe_reg, qe_next;
    logic [32:0]        ser0_reg, ser0_next;
    logic [1:0]         pass_reg, pass_next;
    logic [1:0]         mi_reg, mi_next;
    logic [1:0]         mj_reg, mj_next;
    logic [1:0]         mk_reg, mk_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [1:0]         orow_reg, orow_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MUL_W-1:0]  mul_a, mul_b;

    // combinational helpers
    logic [31:0]        a32;
    logic [29:0]        r30;
    logic [30:0]        rdiff;
    logic               swp;
    logic [7:0]         dval;
    logic [6:0]         shamt;
    logic [63:0]        pu;
    logic [31:0]        qest;
    logic [31:0]        rem;
    logic [31:0]        qf;
    logic [32:0]        res33;
    logic [32:0]        sval, cval;
    logic signed [31:0] fs, fc;
    logic signed [31:0] op_a, op_b;
    logic signed [ACC_W-1:0] sum3, tot, rnd;

    always_comb
    begin
        a32   = {ang_reg[aidx_reg][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
        r30   = a32[29:0];
        swp   = r30 > 30'h2000_0000;
        rdiff = 31'h4000_0000 - {1'b0, r30};
        dval  = ser_div(odd_reg, n_reg);
        shamt = 7'd32 + {4'b0, ser_sh(odd_reg, n_reg)};
        pu    = prod_reg[63:0];
        qest  = 32'(pu >> shamt);
        rem   = v_reg - prod_reg[31:0];
        qf    = qe_reg + ((rem >= {24'b0, dval}) ? 32'd1 : 32'd0);
        res33 = sum_reg[34] ? 33'd0 : sum_reg[32:0];
        sval  = swap_reg ? res33 : ser0_reg;
        cval  = swap_reg ? ser0_reg : res33;
        fs    = to_frac(sval);
        fc    = to_frac(cval);

        case (pass_reg)
            2'd0:
            begin
                op_a = rot_elem(AX_Y, mi_reg, mj_reg, sin_reg[1], cos_reg[1]);
                op_b = rot_elem(AX_Z, mj_reg, mk_reg, sin_reg[2], cos_reg[2]);
            end
            2'd1:
            begin
                op_a = rot_elem(AX_X, mi_reg, mj_reg, sin_reg[0], cos_reg[0]);
                op_b = p_reg[mj_reg][mk_reg];
            end
            2'd2:
            begin
                op_a = q_reg[mi_reg][mj_reg];
                op_b = mdl_reg[mj_reg][mk_reg];
            end
            default:
            begin
                op_a = mdl_reg[mj_reg][mi_reg];
                op_b = mdl_reg[mj_reg][3];
            end
        endcase

        sum3 = acc_reg + {{(ACC_W-64){prod_reg[63]}}, prod_reg[63:0]};
        tot  = sum3 + HALF_ACC;
        rnd  = tot >>> FRAC_BITS;

        // multiplier operand selection
        case (state_reg)
            S_ANG:
            begin
                mul_a = {4'b0, (swp ? rdiff[29:0] : r30)};
                mul_b = {3'b0, TWOPI_LO};
            end
            S_X2:
            begin
                mul_a = {2'b0, x_reg};
                mul_b = {2'b0, x_reg};
            end
            S_T1:
            begin
                mul_a = {1'b0, term_reg};
                mul_b = {2'b0, x2_reg};
            end
            S_T2:
            begin
                mul_a = {2'b0, prod_reg[63:32]};
                mul_b = {2'b0, ser_rcp(odd_reg, n_reg)};
            end
            S_T3:
            begin
                mul_a = {2'b0, qest};
                mul_b = {26'b0, dval};
            end
            S_MMUL:
            begin
                mul_a = {{2{op_a[31]}}, op_a};
                mul_b = {{2{op_b[31]}}, op_b};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        mdl_next   = mdl_reg;
        invt_next  = invt_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        sin_next   = sin_reg;
        cos_next   = cos_reg;
        ang_next   = ang_reg;
        aidx_next  = aidx_reg;
        quad_next  = quad_reg;
        swap_next  = swap_reg;
        rf_next    = rf_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        odd_next   = odd_reg;
        n_next     = n_reg;
        v_next     = v_reg;
        qe_next    = qe_reg;
        ser0_next  = ser0_reg;
        pass_next  = pass_reg;
        mi_next    = mi_reg;
        mj_next    = mj_reg;
        mk_next    = mk_reg;
        acc_next   = acc_reg;
        orow_next  = orow_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ang_next[0] = req.angle_x;
                    ang_next[1] = req.angle_y;
                    ang_next[2] = req.angle_z;
                    pass_next   = PASS_INV;
                    mi_next     = 2'd0;
                    mj_next     = 2'd0;
                    mk_next     = 2'd0;
                    acc_next    = '0;
                    aidx_next   = 2'd0;
                    state_next  = S_MMUL;
                    case (req.cmd)
                        CMD_LOAD:
                        begin
                            if (req.row_sel != 2'd3)
                            begin
                                mdl_next[req.row_sel][0] = req.elem0;
                                mdl_next[req.row_sel][1] = req.elem1;
                                mdl_next[req.row_sel][2] = req.elem2;
                                mdl_next[req.row_sel][3] = req.elem3;
                            end
                        end
                        CMD_TRANS:
                        begin
                            mdl_next[0][3] = sat32(sext32(mdl_reg[0][3]) + sext32(req.elem0));
                            mdl_next[1][3] = sat32(sext32(mdl_reg[1][3]) + sext32(req.elem1));
                            mdl_next[2][3] = sat32(sext32(mdl_reg[2][3]) + sext32(req.elem2));
                        end
                        CMD_ROT:
                        begin
                            pass_next  = 2'd0;
                            state_next = S_ANG;
                        end
                        default:
                        begin
                            state_next = S_MMUL;
                        end
                    endcase
                end
            end
            S_ANG:
            begin
                quad_next  = a32[31:30];
                swap_next  = swp;
                rf_next    = swp ? rdiff[29:0] : r30;
                state_next = S_X;
            end
            S_X:
            begin
                x_next     = ({2'b0, rf_reg} << 2) + ({2'b0, rf_reg} << 1) + prod_reg[63:32];
                state_next = S_X2;
            end
            S_X2:
            begin
                state_next = S_X2W;
            end
            S_X2W:
            begin
                x2_next    = prod_reg[63:32];
                term_next  = {1'b0, x_reg};
                sum_next   = $signed({3'b0, x_reg});
                odd_next   = 1'b1;
                n_next     = 3'd1;
                state_next = S_T1;
            end
            S_T1:
            begin
                state_next = S_T2;
            end
            S_T2:
            begin
                v_next     = prod_reg[63:32];
                state_next = S_T3;
            end
            S_T3:
            begin
                qe_next    = qest;
                state_next = S_T4;
            end
            S_T4:
            begin
                term_next = {1'b0, qf};
                if (n_reg[0])
                    sum_next = sum_reg - $signed({3'b0, qf});
                else
                    sum_next = sum_reg + $signed({3'b0, qf});
                if (n_reg == 3'd7)
                    state_next = S_FIN;
                else
                begin
                    n_next     = n_reg + 3'd1;
                    state_next = S_T1;
                end
            end
            S_FIN:
            begin
                if (odd_reg)
                begin
                    // odd series done, start the even one
                    ser0_next  = res33;
                    odd_next   = 1'b0;
                    term_next  = 33'h1_0000_0000;
                    sum_next   = 35'sh1_0000_0000;
                    n_next     = 3'd1;
                    state_next = S_T1;
                end
                else
                begin
                    case (quad_reg)
                        2'd0:
                        begin
                            sin_next[aidx_reg] = fs;
                            cos_next[aidx_reg] = fc;
                        end
                        2'd1:
                        begin
                            sin_next[aidx_reg] = fc;
                            cos_next[aidx_reg] = -fs;
                        end
                        2'd2:
                        begin
                            sin_next[aidx_reg] = -fs;
                            cos_next[aidx_reg] = -fc;
                        end
                        default:
                        begin
                            sin_next[aidx_reg] = -fc;
                            cos_next[aidx_reg] = fs;
                        end
                    endcase
                    if (aidx_reg == 2'd2)
                    begin
                        pass_next  = 2'd0;
                        mi_next    = 2'd0;
                        mj_next    = 2'd0;
                        mk_next    = 2'd0;
                        acc_next   = '0;
                        state_next = S_MMUL;
                    end
                    else
                    begin
                        aidx_next  = aidx_reg + 2'd1;
                        state_next = S_ANG;
                    end
                end
            end
            S_MMUL:
            begin
                state_next = S_MACC;
            end
            S_MACC:
            begin
                state_next = S_MMUL;
                if (mj_reg != 2'd2)
                begin
                    acc_next = sum3;
                    mj_next  = mj_reg + 2'd1;
                end
                else
                begin
                    acc_next = '0;
                    mj_next  = 2'd0;
                    case (pass_reg)
                        2'd0:    p_next[mi_reg][mk_reg] = sat32(rnd);
                        2'd1:    q_next[mi_reg][mk_reg] = sat32(rnd);
                        2'd2:    p_next[mi_reg][mk_reg] = sat32(rnd);
                        default: invt_next[mi_reg]      = sat32(-rnd);
                    endcase
                    if (pass_reg == PASS_INV)
                    begin
                        if (mi_reg == 2'd2)
                        begin
                            orow_next  = 2'd0;
                            state_next = S_OUT;
                        end
                        else
                            mi_next = mi_reg + 2'd1;
                    end
                    else if (mk_reg != 2'd2)
                        mk_next = mk_reg + 2'd1;
                    else
                    begin
                        mk_next = 2'd0;
                        if (mi_reg != 2'd2)
                            mi_next = mi_reg + 2'd1;
                        else
                        begin
                            mi_next = 2'd0;
                            if (pass_reg == 2'd2)
                                state_next = S_COPY;
                            else
                                pass_next = pass_reg + 2'd1;
                        end
                    end
                end
            end
            S_COPY:
            begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        mdl_next[r][c] = p_reg[r][c];
                pass_next  = PASS_INV;
                mi_next    = 2'd0;
                mj_next    = 2'd0;
                mk_next    = 2'd0;
                state_next = S_MMUL;
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    if (orow_reg == 2'd2)
                        state_next = S_IDLE;
                    else
                        orow_next = orow_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                    mdl_reg[r][c] <= (r == c) ? ONE_FX : '0;
                invt_reg[r] <= '0;
            end
            aidx_reg <= '0;
            odd_reg  <= 1'b0;
            n_reg    <= '0;
            pass_reg <= '0;
            mi_reg   <= '0;
            mj_reg   <= '0;
            mk_reg   <= '0;
            orow_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mdl_reg   <= mdl_next;
            invt_reg  <= invt_next;
            aidx_reg  <= aidx_next;
            odd_reg   <= odd_next;
            n_reg     <= n_next;
            pass_reg  <= pass_next;
            mi_reg    <= mi_next;
            mj_reg    <= mj_next;
            mk_reg    <= mk_next;
            orow_reg  <= orow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        q_reg    <= q_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        ang_reg  <= ang_next;
        quad_reg <= quad_next;
        swap_reg <= swap_next;
        rf_reg   <= rf_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        v_reg    <= v_next;
        qe_reg   <= qe_next;
        ser0_reg <= ser0_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    always_comb
    begin
        rsp.out_row  = orow_reg;
        rsp.mat_c0   = mdl_reg[orow_reg][0];
        rsp.mat_c1   = mdl_reg[orow_reg][1];
        rsp.mat_c2   = mdl_reg[orow_reg][2];
        rsp.mat_c3   = mdl_reg[orow_reg][3];
        // inverse rotation is the transpose
        rsp.inv_c0   = mdl_reg[0][orow_reg];
        rsp.inv_c1   = mdl_reg[1][orow_reg];
        rsp.inv_c2   = mdl_reg[2][orow_reg];
        rsp.inv_c3   = invt_reg[orow_reg];
        rsp.last_row = (orow_reg == 2'd2);
    end

endmodule

`default_nettype wire

// ===== rtl/rtu_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtu_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire rtu_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire rtu_pkg::rsp_t rsp
);
    import rtu_pkg::*;

    // no new command while results are still being emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("ready while results pending");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready && !rsp_valid)
        else $error("block not busy after command accepted");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp.last_row |=>
            rsp_valid && (rsp.out_row == $past(rsp.out_row) + 2'd1))
        else $error("result rows out of order");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp.last_row |=> req_ready)
        else $error("not ready after final row");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind rigid_transform_update rtu_check u_rtu_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ===== bench/tb_rigid_transform_update.sv =====
`timescale 1ns / 1ps

module tb_rigid_transform_update;
    import rtu_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [1:0] ROW_NONE = 2'd3;
    localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
    localparam longint unsigned ONE_Q32 = 64'd4294967296;
    localparam longint ONE = 64'sd1 << FRAC_BITS;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_item;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_item;

    rigid_transform_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_item)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predicted pose: row-major 3x4 model matrix and its inverse
    longint pose[12];
    longint pose_inv[12];
    rsp_t pose_rows_q[$];
    int errors = 0;
    bit calm = 0;
    int hold_cycles = 0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // exact sum of three products, rounded half up
    function automatic longint round_dot3(input longint a0, input longint b0,
                                          input longint a1, input longint b1,
                                          input longint a2, input longint b2);
        longint p[3];
        longint qs;
        longint rs;
        longint q;
        p[0] = a0 * b0;
        p[1] = a1 * b1;
        p[2] = a2 * b2;
        qs = 0;
        rs = 0;
        for (int i = 0; i < 3; i++)
        begin
            q = p[i] >>> FRAC_BITS;
            qs += q;
            rs += p[i] - (q <<< FRAC_BITS);
        end
        rs += 64'sd1 <<< (FRAC_BITS - 1);
        return qs + (rs >>> FRAC_BITS);
    endfunction

    function automatic void mat_mul3(input longint a[9], input longint b[9],
                                     output longint c[9]);
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                c[r*3+k] = clamp32(round_dot3(a[r*3], b[k], a[r*3+1], b[3+k],
                                              a[r*3+2], b[6+k]));
    endfunction

    function automatic longint unsigned taylor_q32(input longint unsigned x,
                                                   input bit odd);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint sum;
        x2 = (x * x) >> 32;
        term = odd ? x : ONE_Q32;
        sum = longint'(term);
        for (int n = 1; n <= 7; n++)
        begin
            d = odd ? longint'((2*n) * (2*n+1)) : longint'((2*n-1) * (2*n));
            term = ((term * x2) >> 32) / d;
            if (n & 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint s,
                                    output longint c);
        longint unsigned a;
        longint unsigned r;
        longint unsigned x;
        longint unsigned s0;
        longint unsigned c0;
        longint fs;
        longint fc;
        logic [1:0] quad;
        a = {32'd0, ang, 16'd0};
        quad = a[31:30];
        r = a & 64'h3FFF_FFFF;
        if (r <= 64'h2000_0000)
        begin
            x = (r * TWO_PI_Q32) >> 32;
            s0 = taylor_q32(x, 1'b1);
            c0 = taylor_q32(x, 1'b0);
        end
        else
        begin
            x = ((64'h4000_0000 - r) * TWO_PI_Q32) >> 32;
            s0 = taylor_q32(x, 1'b0);
            c0 = taylor_q32(x, 1'b1);
        end
        fs = longint'((s0 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
        fc = longint'((c0 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
        case (quad)
            2'd0: begin s = fs;  c = fc;  end
            2'd1: begin s = fc;  c = -fs; end
            2'd2: begin s = -fs; c = -fc; end
            default: begin s = -fc; c = fs; end
        endcase
    endfunction

    function automatic void rotate_pose(input logic [15:0] ax, input logic [15:0] ay,
                                        input logic [15:0] az);
        longint sx, cx, sy, cy, sz, cz;
        longint rx[9], ry[9], rz[9], p[9], q[9], r[9], n[9];
        sin_cos(ax, sx, cx);
        sin_cos(ay, sy, cy);
        sin_cos(az, sz, cz);
        rx = '{ONE, 0, 0, 0, cx, -sx, 0, sx, cx};
        ry = '{cy, 0, sy, 0, ONE, 0, -sy, 0, cy};
        rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, ONE};
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                r[i*3+k] = pose[i*4+k];
        mat_mul3(ry, rz, p);
        mat_mul3(rx, p, q);
        mat_mul3(q, r, n);
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                pose[i*4+k] = n[i*3+k];
    endfunction

    // apply one command and queue the three rows that it emits
    function automatic void advance_pose(input req_t c);
        rsp_t row;
        case (c.cmd)
            CMD_LOAD:
                if (c.row_sel != ROW_NONE)
                begin
                    pose[c.row_sel*4]   = c.elem0;
                    pose[c.row_sel*4+1] = c.elem1;
                    pose[c.row_sel*4+2] = c.elem2;
                    pose[c.row_sel*4+3] = c.elem3;
                end
            CMD_TRANS:
            begin
                pose[3]  = clamp32(pose[3] + longint'(c.elem0));
                pose[7]  = clamp32(pose[7] + longint'(c.elem1));
                pose[11] = clamp32(pose[11] + longint'(c.elem2));
            end
            CMD_ROT:
                rotate_pose(c.angle_x, c.angle_y, c.angle_z);
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                pose_inv[i*4+k] = pose[k*4+i];
            pose_inv[i*4+3] = clamp32(-round_dot3(pose[i], pose[3], pose[4+i], pose[7],
                                                  pose[8+i], pose[11]));
        end
        for (int k = 0; k < 3; k++)
        begin
            row.out_row  = 2'(k);
            row.mat_c0   = 32'(pose[k*4]);
            row.mat_c1   = 32'(pose[k*4+1]);
            row.mat_c2   = 32'(pose[k*4+2]);
            row.mat_c3   = 32'(pose[k*4+3]);
            row.inv_c0   = 32'(pose_inv[k*4]);
            row.inv_c1   = 32'(pose_inv[k*4+1]);
            row.inv_c2   = 32'(pose_inv[k*4+2]);
            row.inv_c3   = 32'(pose_inv[k*4+3]);
            row.last_row = (k == 2);
            pose_rows_q.push_back(row);
        end
    endfunction

    task automatic send_cmd(input req_t c);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= c;
        do
            @(posedge clk);
        while (!req_ready);
        advance_pose(c);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pose_rows_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic req_t make_cmd(input logic [1:0] cmd, input logic [1:0] row,
                                      input logic [31:0] e0, input logic [31:0] e1,
                                      input logic [31:0] e2, input logic [31:0] e3,
                                      input logic [15:0] ax, input logic [15:0] ay,
                                      input logic [15:0] az);
        req_t c;
        c = '{cmd, row, e0, e1, e2, e3, ax, ay, az};
        return c;
    endfunction

    function automatic logic [31:0] rand_q(input bit full);
        if (full)
            return $urandom;
        return 32'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic req_t rand_cmd();
        req_t c;
        int pick;
        pick = $urandom_range(0, 99);
        c = make_cmd(CMD_NOP, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        if (pick < 35)
        begin
            c.cmd = CMD_LOAD;
            c.row_sel = 2'($urandom_range(0, 2));
            c.elem0 = rand_q(pick < 10);
            c.elem1 = rand_q(pick < 10);
            c.elem2 = rand_q(pick < 10);
            c.elem3 = rand_q(pick < 20);
        end
        else if (pick < 60)
        begin
            c.cmd = CMD_TRANS;
            if (pick < 52)
            begin
                c.elem0 = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
                c.elem1 = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
                c.elem2 = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            end
        end
        else if (pick < 92)
            c.cmd = CMD_ROT;
        else if (pick < 96)
            c.row_sel = ROW_NONE;
        return c;
    endfunction

    task automatic test_reset_state();
        send_cmd(make_cmd(CMD_NOP, 2'd0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_load_rows();
        send_cmd(make_cmd(CMD_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(CMD_LOAD, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                          32'h8000_0000, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 2'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, ROW_NONE, 32'h1234_5678, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_NOP, 2'd2, 32'h1234_5678, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_translate();
        send_cmd(make_cmd(CMD_LOAD, 2'd0, 32'(ONE), 0, 0, 32'h7FFF_FFF0, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 2'd1, 0, 32'(ONE), 0, 32'h8000_0010, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 2'd2, 0, 0, 32'(ONE), 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_TRANS, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
                          0, 0, 0, 0));
        send_cmd(make_cmd(CMD_TRANS, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                          0, 0, 0, 0));
        drain();
    endtask

    task automatic test_rotate();
        logic [15:0] angles[8];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'h2001,
                   16'hFFFF, 16'h1555};
        send_cmd(make_cmd(CMD_LOAD, 2'd0, 32'(ONE), 0, 0, 32'h0003_0000, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 2'd1, 0, 32'(ONE), 0, 32'hFFFE_8000, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 2'd2, 0, 0, 32'(ONE), 32'h0000_4000, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            send_cmd(make_cmd(CMD_ROT, 2'd0, 0, 0, 0, 0, angles[i], angles[(i+3)%8],
                              angles[(i+5)%8]));
        drain();
    endtask

    // hold the result side off while commands keep coming
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 5; i++)
            send_cmd(rand_cmd());
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count - 20)
                calm = 1;
            send_cmd(rand_cmd());
        end
        drain();
    endtask

    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
            errors++;
        end
    endtask

    task automatic check_row(input rsp_t got);
        rsp_t e;
        if (pose_rows_q.size() == 0)
        begin
            $display("%0t: unexpected row, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        e = pose_rows_q.pop_front();
        check_field("out_row", e.out_row, got.out_row);
        check_field("mat_c0", e.mat_c0, got.mat_c0);
        check_field("mat_c1", e.mat_c1, got.mat_c1);
        check_field("mat_c2", e.mat_c2, got.mat_c2);
        check_field("mat_c3", e.mat_c3, got.mat_c3);
        check_field("inv_c0", e.inv_c0, got.inv_c0);
        check_field("inv_c1", e.inv_c1, got.inv_c1);
        check_field("inv_c2", e.inv_c2, got.inv_c2);
        check_field("inv_c3", e.inv_c3, got.inv_c3);
        check_field("last_row", e.last_row, got.last_row);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                check_row(rsp_item);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 15) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_rigid_transform_update: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        rsp_ready = 1'b0;
        for (int i = 0; i < 12; i++)
            pose[i] = (i % 5 == 0) ? ONE : 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_state();
        test_load_rows();
        test_translate();
        test_rotate();
        test_backpressure();
        test_random(83);
        if (errors == 0 && pose_rows_q.size() == 0)
            $display("tb_rigid_transform_update: PASS");
        else
            $display("tb_rigid_transform_update: FAIL");
        $finish;
    end

endmodule
